[rtl/core/digest_match_run_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Digest match run tracker assertion macros
// Shared immediate-implication and next-cycle forms for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DIGEST_MATCH_RUN_TRACKER_MACROS_SVH
`define DIGEST_MATCH_RUN_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmrt check failed");

// The consequent must hold in the cycle after the antecedent.
`define DMRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmrt check failed");

`endif

[rtl/core/dmrt_pkg.sv]
// ----------------------------------------------------------------------------
// Digest match run tracker package
// Shared widths, codes, defaults and types.
// ----------------------------------------------------------------------------
package dmrt_pkg;

  // Default geometry of the digest table and bucket index.
  localparam int DEF_TABLE_ENTRIES = 4096;
  localparam int DEF_KEY_BITS      = 12;

  // Field widths.
  localparam int LINE_W     = 24;
  localparam int SLOT_OUT_W = 12;
  localparam int USE_W      = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [USE_W-1:0] USE_MAX = '1;

  // Item modes.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_MATCH = 2'd0;
  localparam logic [1:0] REG_FUZZ  = 2'd1;
  localparam logic [1:0] REG_USES  = 2'd2;

  // Register reset values.
  localparam logic [LINE_W-1:0] RST_MATCH = 24'd1;
  localparam logic [LINE_W-1:0] RST_FUZZ  = 24'd5;
  localparam logic [USE_W-1:0]  RST_USES  = 16'd1;

  typedef struct packed {
    logic [1:0]        mode;
    logic [63:0]       digest_high;
    logic [63:0]       digest_low;
    logic [LINE_W-1:0] line_number;
  } item_t;

  // Head of the queue between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

  typedef struct packed {
    logic [LINE_W-1:0] match_thr;
    logic [LINE_W-1:0] fuzz_thr;
    logic [USE_W-1:0]  use_limit;
  } cfg_t;

endpackage

[rtl/core/dmrt_if.sv]
// ----------------------------------------------------------------------------
// Digest match run tracker channels
// Valid/ready interfaces for the item channel and the result channel.
// ----------------------------------------------------------------------------
interface dmrt_in_if import dmrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [63:0]       digest_high;
  logic [63:0]       digest_low;
  logic [LINE_W-1:0] line_number;

  modport source (output valid, mode, digest_high, digest_low, line_number, input ready);
  modport sink (input valid, mode, digest_high, digest_low, line_number, output ready);
endinterface

interface dmrt_out_if import dmrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [LINE_W-1:0]     run_start;
  logic [LINE_W-1:0]     run_end;
  logic [SLOT_OUT_W-1:0] entry_slot;

  modport source (output valid, run_start, run_end, entry_slot, input ready);
  modport sink (input valid, run_start, run_end, entry_slot, output ready);
endinterface

[rtl/core/digest_match_run_tracker.sv]
// A load or query reads the bucket head, then walks the bucket chain one entry at a time.
// A flush is handled in the idle state; results appear in the output register the cycle after.
// Throughput is set by the back end's bucket walk over registered-read RAMs.
// A two-beat queue lets items be accepted while the back end is busy.
// After reset a clearing pass over all 2**KEY_BITS buckets empties the bucket index;
// no item is accepted during it, while register writes are taken as usual.
// ----------------------------------------------------------------------------
// Digest match run tracker
// Digest table with bucket lookup, use counts and match run reporting.
// ----------------------------------------------------------------------------
module digest_match_run_tracker import dmrt_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = DEF_KEY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dmrt_in_if.sink               in_ch,
  dmrt_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t       cfg_r;
  q_t         head;
  logic       pop;
  logic       busy_clear;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_thr <= RST_MATCH;
      cfg_r.fuzz_thr  <= RST_FUZZ;
      cfg_r.use_limit <= RST_USES;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MATCH: cfg_r.match_thr <= cfg_pwdata[LINE_W-1:0];
        REG_FUZZ:  cfg_r.fuzz_thr  <= cfg_pwdata[LINE_W-1:0];
        REG_USES:  cfg_r.use_limit <= cfg_pwdata[USE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (cfg_idx)
      REG_MATCH: cfg_prdata = CFG_DATA_W'(cfg_r.match_thr);
      REG_FUZZ:  cfg_prdata = CFG_DATA_W'(cfg_r.fuzz_thr);
      REG_USES:  cfg_prdata = CFG_DATA_W'(cfg_r.use_limit);
      default:   cfg_prdata = '0;
    endcase
  end

  dmrt_front u_front (
    .clk, .rst_n, .in_ch, .enable(!busy_clear), .pop, .head);

  dmrt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .head, .pop, .busy_clear, .out_ch);

endmodule

[rtl/core/dmrt_ram.sv]
// ----------------------------------------------------------------------------
// Digest match run tracker RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dmrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dmrt_front.sv]
// ----------------------------------------------------------------------------
// Digest match run tracker front end
// Accepts item beats, drops unknown modes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module dmrt_front import dmrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dmrt_in_if.sink   in_ch,
  input  logic      enable,
  input  logic      pop,
  output q_t        head
);

  item_t      q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  item_t      in_item;

  assign in_item = '{mode: in_ch.mode, digest_high: in_ch.digest_high,
                     digest_low: in_ch.digest_low, line_number: in_ch.line_number};

  // Accept while enabled and there is room; an unknown mode is taken and discarded.
  assign in_ch.ready = enable && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && (in_ch.mode != MODE_NONE);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Queue pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

[rtl/core/dmrt_back.sv]
// ----------------------------------------------------------------------------
// Digest match run tracker back end
// Walks bucket chains, inserts loads, counts uses and tracks the open run.
// ----------------------------------------------------------------------------
`include "digest_match_run_tracker_macros.svh"

module dmrt_back import dmrt_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = DEF_KEY_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  q_t         head,
  output logic       pop,
  output logic       busy_clear,
  dmrt_out_if.source out_ch
);

  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int BUCKETS = 1 << KEY_BITS;
  localparam logic [IDX_W-1:0] EMPTY = IDX_W'(TABLE_ENTRIES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HEAD  = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [KEY_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  item_t               cur_r, cur_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    entry_cnt_r, entry_cnt_nxt;
  logic                run_open_r, run_open_nxt;
  logic [LINE_W-1:0]   open_start_r, open_start_nxt;
  logic [LINE_W-1:0]   open_end_r, open_end_nxt;
  logic [SLOT_W-1:0]   open_slot_r, open_slot_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0]     out_start_r, out_start_nxt;
  logic [LINE_W-1:0]     out_end_r, out_end_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic                  emit;

  // Memory ports.
  logic                ins_we;
  logic [SLOT_W-1:0]   ins_addr;
  logic [SLOT_W-1:0]   slot_raddr;
  logic [63:0]         hi_rdata, lo_rdata;
  logic [IDX_W-1:0]    link_rdata;
  logic [IDX_W-1:0]    link_wdata;
  logic                use_we;
  logic [SLOT_W-1:0]   use_waddr;
  logic [USE_W-1:0]    use_wdata, use_rdata;
  logic                bk_we;
  logic [KEY_BITS-1:0] bk_waddr, bk_raddr;
  logic [IDX_W-1:0]    bk_wdata, bk_rdata;

  logic                  out_free, qualify, full, match, ext, over;
  logic [USE_W-1:0]      use_inc;
  logic [LINE_W+1:0]     reach;

  assign ins_addr   = entry_cnt_r[SLOT_W-1:0];
  assign full       = (entry_cnt_r == EMPTY);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign busy_clear = (state_r == ST_CLEAR);

  // A new entry links to the old bucket head; in the head state it is still on the read port.
  assign link_wdata = (state_r == ST_HEAD) ? bk_rdata : head_r;

  // Bucket key is the top bits of the digest.
  assign bk_raddr = (state_r == ST_IDLE) ? head.item.digest_high[63 -: KEY_BITS]
                                          : cur_r.digest_high[63 -: KEY_BITS];
  assign slot_raddr = (state_r == ST_HEAD) ? bk_rdata[SLOT_W-1:0]
                                           : link_rdata[SLOT_W-1:0];

  // Run close test and hit arithmetic.
  assign qualify = run_open_r && (open_end_r >= open_start_r) &&
                   ((open_end_r - open_start_r) >= cfg.match_thr);
  assign match   = (hi_rdata == cur_r.digest_high) && (lo_rdata == cur_r.digest_low);
  assign use_inc = (use_rdata == USE_MAX) ? use_rdata : use_rdata + USE_W'(1);
  assign reach   = {2'b00, open_end_r} + (LINE_W+2)'(1) + {2'b00, cfg.fuzz_thr};
  assign ext     = run_open_r && (reach >= {2'b00, cur_r.line_number});
  assign over    = (use_inc > cfg.use_limit);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_nxt        = cur_r;
    idx_nxt        = idx_r;
    head_nxt       = head_r;
    entry_cnt_nxt  = entry_cnt_r;
    run_open_nxt   = run_open_r;
    open_start_nxt = open_start_r;
    open_end_nxt   = open_end_r;
    open_slot_nxt  = open_slot_r;
    emit           = 1'b0;
    pop            = 1'b0;
    ins_we         = 1'b0;
    use_we         = 1'b0;
    use_waddr      = ins_addr;
    use_wdata      = '0;
    bk_we          = 1'b0;
    bk_waddr       = cur_r.digest_high[63 -: KEY_BITS];
    bk_wdata       = entry_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        // Mark every bucket empty after reset.
        bk_we       = 1'b1;
        bk_waddr    = clr_cnt_r;
        bk_wdata    = EMPTY;
        clr_cnt_nxt = clr_cnt_r + KEY_BITS'(1);
        if (clr_cnt_r == KEY_BITS'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head.valid && out_free) begin
          pop     = 1'b1;
          cur_nxt = head.item;
          unique case (head.item.mode)
            MODE_LOAD: begin
              if (!full) begin
                state_nxt = ST_HEAD;
              end
            end
            MODE_QUERY: begin
              state_nxt = ST_HEAD;
            end
            MODE_FLUSH: begin
              emit           = qualify;
              run_open_nxt   = 1'b0;
              open_start_nxt = '0;
              open_end_nxt   = '0;
              open_slot_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_HEAD: begin
        head_nxt = bk_rdata;
        idx_nxt  = bk_rdata;
        if (bk_rdata == EMPTY) begin
          state_nxt = ST_IDLE;
          if (cur_r.mode == MODE_LOAD) begin
            ins_we        = 1'b1;
            use_we        = 1'b1;
            bk_we         = 1'b1;
            entry_cnt_nxt = entry_cnt_r + IDX_W'(1);
          end
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (match) begin
          state_nxt = ST_IDLE;
          if (cur_r.mode == MODE_QUERY) begin
            // Hit: bump the use count; extend the open run, or open a new one unless over the use limit.
            use_we    = 1'b1;
            use_waddr = idx_r[SLOT_W-1:0];
            use_wdata = use_inc;
            if (ext) begin
              open_end_nxt = cur_r.line_number;
            end else if (!over) begin
              emit           = qualify;
              run_open_nxt   = 1'b1;
              open_start_nxt = cur_r.line_number;
              open_end_nxt   = cur_r.line_number;
              open_slot_nxt  = idx_r[SLOT_W-1:0];
            end
          end
        end else if (link_rdata == EMPTY) begin
          state_nxt = ST_IDLE;
          if (cur_r.mode == MODE_LOAD) begin
            ins_we        = 1'b1;
            use_we        = 1'b1;
            bk_we         = 1'b1;
            entry_cnt_nxt = entry_cnt_r + IDX_W'(1);
          end
        end else begin
          idx_nxt = link_rdata;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_slot_nxt  = out_slot_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_start_nxt = open_start_r;
      out_end_nxt   = open_end_r;
      out_slot_nxt  = SLOT_OUT_W'(open_slot_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.run_start  = out_start_r;
  assign out_ch.run_end    = out_end_r;
  assign out_ch.entry_slot = out_slot_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      entry_cnt_r  <= '0;
      run_open_r   <= 1'b0;
      open_start_r <= '0;
      open_end_r   <= '0;
      open_slot_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      run_open_r   <= run_open_nxt;
      open_start_r <= open_start_nxt;
      open_end_r   <= open_end_nxt;
      open_slot_r  <= open_slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    idx_r       <= idx_nxt;
    head_r      <= head_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_slot_r  <= out_slot_nxt;
  end

  // Table memories.
  dmrt_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_hi (
    .clk, .we(ins_we), .waddr(ins_addr), .wdata(cur_r.digest_high),
    .raddr(slot_raddr), .rdata(hi_rdata));
  dmrt_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_lo (
    .clk, .we(ins_we), .waddr(ins_addr), .wdata(cur_r.digest_low),
    .raddr(slot_raddr), .rdata(lo_rdata));
  dmrt_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_ENTRIES)) u_link (
    .clk, .we(ins_we), .waddr(ins_addr), .wdata(link_wdata),
    .raddr(slot_raddr), .rdata(link_rdata));
  dmrt_ram #(.WIDTH(USE_W), .DEPTH(TABLE_ENTRIES)) u_use (
    .clk, .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
    .raddr(slot_raddr), .rdata(use_rdata));
  dmrt_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_bucket (
    .clk, .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata));

  // Checks.
  `DMRT_ASSERT_SAME(a_pop_idle, pop, state_r == ST_IDLE)
  `DMRT_ASSERT_SAME(a_emit_free, emit, out_free)
  `DMRT_ASSERT_SAME(a_count_bound, 1'b1, entry_cnt_r <= EMPTY)
  `DMRT_ASSERT_NEXT(a_insert_grows, ins_we, entry_cnt_r == $past(entry_cnt_r) + IDX_W'(1))

endmodule

[sim/digest_match_run_tracker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digest match run tracker testbench
// Loads digests, queries them along a moving line cursor and flushes runs,
// under several register settings and idling patterns. Every reported run is
// compared against an in-bench prediction of the table, use counts and runs.
// ----------------------------------------------------------------------------
module digest_match_run_tracker_tb;
  import dmrt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PHASE_ITEMS  = 115;

  typedef struct packed {
    logic [LINE_W-1:0]     run_start;
    logic [LINE_W-1:0]     run_end;
    logic [SLOT_OUT_W-1:0] entry_slot;
  } run_t;

  // Predicts the digest table, the use counts and the open run.
  class run_scoreboard;
    logic [LINE_W-1:0]     match_thr;
    logic [LINE_W-1:0]     fuzz_thr;
    logic [USE_W-1:0]      use_limit;
    int                    slot_of [logic [127:0]];
    logic [USE_W-1:0]      uses [DEF_TABLE_ENTRIES];
    int                    entries;
    bit                    run_open;
    logic [LINE_W-1:0]     open_start;
    logic [LINE_W-1:0]     open_end;
    logic [SLOT_OUT_W-1:0] open_slot;
    run_t                  pending_runs [$];
    int                    errors;
    int                    runs_seen;

    function new();
      match_thr  = RST_MATCH;
      fuzz_thr   = RST_FUZZ;
      use_limit  = RST_USES;
      entries    = 0;
      run_open   = 0;
      open_start = '0;
      open_end   = '0;
      open_slot  = '0;
      errors     = 0;
      runs_seen  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_MATCH: match_thr = val[LINE_W-1:0];
        REG_FUZZ:  fuzz_thr  = val[LINE_W-1:0];
        REG_USES:  use_limit = val[USE_W-1:0];
        default: ;
      endcase
    endfunction

    // A closing run is reported only when its span reaches the threshold.
    function void close_run();
      run_t r;
      if (run_open && open_end >= open_start && (open_end - open_start) >= match_thr) begin
        r.run_start  = open_start;
        r.run_end    = open_end;
        r.entry_slot = open_slot;
        pending_runs.push_back(r);
      end
      run_open   = 0;
      open_start = '0;
      open_end   = '0;
      open_slot  = '0;
    endfunction

    function void note_item(item_t it);
      logic [127:0] dg;
      int           s;
      dg = {it.digest_high, it.digest_low};
      case (it.mode)
        MODE_LOAD: begin
          if (entries < DEF_TABLE_ENTRIES && !slot_of.exists(dg)) begin
            slot_of[dg]   = entries;
            uses[entries] = '0;
            entries++;
          end
        end
        MODE_QUERY: begin
          if (slot_of.exists(dg)) begin
            s = slot_of[dg];
            if (uses[s] != USE_MAX) uses[s]++;
            if (run_open && ({2'b00, open_end} + 26'd1 + {2'b00, fuzz_thr} >=
                             {2'b00, it.line_number})) begin
              open_end = it.line_number;
            end else if (uses[s] <= use_limit) begin
              close_run();
              run_open   = 1;
              open_start = it.line_number;
              open_end   = it.line_number;
              open_slot  = s[SLOT_OUT_W-1:0];
            end
          end
        end
        MODE_FLUSH: close_run();
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(run_t got);
      run_t want;
      runs_seen++;
      if (pending_runs.size() == 0) begin
        report_mismatch($sformatf("unexpected run %0d..%0d slot %0d",
                                  got.run_start, got.run_end, got.entry_slot));
      end else begin
        want = pending_runs.pop_front();
        if (got.run_start !== want.run_start)
          report_mismatch($sformatf("run_start %0h, expected %0h", got.run_start,
                                    want.run_start));
        if (got.run_end !== want.run_end)
          report_mismatch($sformatf("run_end %0h, expected %0h", got.run_end, want.run_end));
        if (got.entry_slot !== want.entry_slot)
          report_mismatch($sformatf("entry_slot %0d, expected %0d", got.entry_slot,
                                    want.entry_slot));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dmrt_in_if  in_ch ();
  dmrt_out_if out_ch ();

  digest_match_run_tracker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  run_scoreboard sb;

  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_cycles;
  int               items_sent;
  int               cycle_count;
  logic [23:0]      line_cursor;
  logic [11:0]      chain_keys [4];
  logic [127:0]     loaded_pool [$];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Timeout guard.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: check each accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.run_start, out_ch.run_end, out_ch.entry_slot});
      if (hold_cycles > 0) begin
        hold_cycles  <= hold_cycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // One register write: setup cycle, then access cycle.
  task cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task set_regs(logic [23:0] match, logic [23:0] fuzz, logic [15:0] uses);
    cfg_write(REG_MATCH, {8'($urandom_range(0, 255)), match});
    cfg_write(REG_FUZZ, {8'($urandom_range(0, 255)), fuzz});
    cfg_write(REG_USES, {16'($urandom_range(0, 65535)), uses});
  endtask

  // Offer one beat and hold it until the block takes it.
  task send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= it.mode;
    in_ch.digest_high <= it.digest_high;
    in_ch.digest_low  <= it.digest_low;
    in_ch.line_number <= it.line_number;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
    if (it.mode == MODE_LOAD) loaded_pool.push_back({it.digest_high, it.digest_low});
  endtask

  task send(logic [1:0] mode, logic [127:0] dg, logic [23:0] line);
    send_item('{mode, dg[127:64], dg[63:0], line});
  endtask

  // Wait for every expected run, then let the back end finish silent items.
  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_runs.size() != 0 || hold_cycles != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [127:0] fresh_digest();
    logic [127:0] dg;
    dg = {$urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 1)) dg[127:116] = chain_keys[$urandom_range(0, 3)];
    return dg;
  endfunction

  // Random beat: mostly queries that walk the line cursor over loaded digests.
  function automatic item_t random_item();
    item_t        it;
    int           pick;
    logic [127:0] dg;
    pick = $urandom_range(0, 99);
    dg   = fresh_digest();
    it.line_number = 24'($urandom);
    if (pick < 20) begin
      it.mode = MODE_LOAD;
      if (pick < 3 && loaded_pool.size() > 0)
        dg = loaded_pool[$urandom_range(0, loaded_pool.size() - 1)];
    end else if (pick < 88) begin
      it.mode = MODE_QUERY;
      if (pick < 80 && loaded_pool.size() > 0)
        dg = loaded_pool[$urandom_range(0, loaded_pool.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 70)      line_cursor = line_cursor + 24'($urandom_range(0, 4));
      else if (pick < 88) line_cursor = line_cursor + 24'($urandom_range(6, 60));
      else if (pick < 96) line_cursor = line_cursor - 24'($urandom_range(1, 10));
      else                line_cursor = 24'($urandom);
      it.line_number = line_cursor;
    end else if (pick < 96) begin
      it.mode = MODE_FLUSH;
    end else begin
      it.mode = MODE_NONE;
    end
    it.digest_high = dg[127:64];
    it.digest_low  = dg[63:0];
    return it;
  endfunction

  task directed_items();
    logic [127:0] d_zero, d_ones, d_chain, d_mid;
    d_zero  = '0;
    d_ones  = '1;
    d_chain = {12'hFFF, 52'h0, 64'h1};
    d_mid   = fresh_digest();
    send(MODE_LOAD, d_zero, 24'hFFFFFF);
    send(MODE_LOAD, d_ones, '0);
    send(MODE_LOAD, d_chain, '0);
    // Duplicate load is dropped.
    send(MODE_LOAD, d_ones, '0);
    // Flush with nothing open.
    send(MODE_FLUSH, d_ones, 24'hFFFFFF);
    send(MODE_QUERY, d_zero, 24'd0);
    send(MODE_QUERY, d_chain, 24'd3);
    // A load while a run is open keeps the run.
    send(MODE_LOAD, d_mid, '0);
    // Backward line still extends.
    send(MODE_QUERY, d_ones, 24'd2);
    // Miss.
    send(MODE_QUERY, fresh_digest(), 24'd4);
    send(MODE_NONE, d_ones, 24'hFFFFFF);
    send(MODE_FLUSH, '0, '0);
    send(MODE_QUERY, d_mid, 24'hFFFFF0);
    send(MODE_QUERY, d_mid, 24'hFFFFFF);
    send(MODE_FLUSH, '0, '0);
    // Overused entry cannot open a run.
    send(MODE_QUERY, d_chain, 24'd10);
    send(MODE_QUERY, d_ones, 24'd40);
    send(MODE_FLUSH, d_zero, '0);
    // Overused entry queried again at a falling line opens no run.
    send(MODE_QUERY, d_zero, 24'd100);
    send(MODE_QUERY, d_zero, 24'd50);
    send(MODE_FLUSH, '0, '0);
    drain();
  endtask

  initial begin
    logic [127:0] d_sat;
    int           k;
    sb             = new();
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_NONE;
    in_ch.digest_high = '0;
    in_ch.digest_low  = '0;
    in_ch.line_number = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    items_sent     = 0;
    line_cursor    = '0;
    for (k = 0; k < 4; k++) chain_keys[k] = 12'($urandom);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset settings, both sides steady.
    directed_items();

    // Random phases across register settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(24'd0, 24'd0, 16'd0);
        1: set_regs(24'd2, 24'd3, 16'd3);
        2: set_regs(24'd5, 24'd8, 16'hFFFF);
        3: set_regs(24'hFFFFFF, 24'hFFFFFF, 16'd1);
        4: set_regs(24'd1, 24'd5, 16'd2);
        default: set_regs(24'd0, 24'd2, 16'd6);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item());
      send(MODE_FLUSH, '0, '0);
      drain();
    end

    // Receiver holds off while each query after the first closes a reportable run.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_regs(24'd0, 24'd0, 16'hFFFF);
    d_sat = fresh_digest();
    send(MODE_LOAD, d_sat, '0);
    hold_cycles = 400;
    for (k = 0; k < 24; k++) send(MODE_QUERY, d_sat, 24'(1000 + 100 * k));
    send(MODE_FLUSH, '0, '0);
    drain();

    if (sb.pending_runs.size() != 0)
      sb.report_mismatch($sformatf("%0d expected runs never arrived", sb.pending_runs.size()));
    $display("Sent %0d beats over six register settings and four idling patterns,", items_sent);
    $display("plus a long receiver hold-off; %0d runs checked, %0d mismatches.",
             sb.runs_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
